@@ rtl/ede_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ede_pkg;

  localparam int VALUE_W = 27;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 40;

  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_BUTTON = 2'd1;
  localparam logic [1:0] REQ_TURN   = 2'd2;

  localparam logic [1:0] MODE_INTENSITY = 2'd0;
  localparam logic [1:0] MODE_IDENTITY  = 2'd1;
  localparam logic [1:0] MODE_PIN       = 2'd2;
  localparam logic [1:0] MODE_OPEN      = 2'd3;

  localparam logic [2:0] BTN_PRESS     = 3'd0;
  localparam logic [2:0] BTN_RELEASE   = 3'd1;
  localparam logic [2:0] BTN_LONG      = 3'd2;
  localparam logic [2:0] BTN_TYPEMATIC = 3'd3;
  localparam logic [2:0] BTN_NONE      = 3'd4;

  localparam logic [1:0] EVT_NONE    = 2'd0;
  localparam logic [1:0] EVT_NUMBER  = 2'd1;
  localparam logic [1:0] EVT_ERROR   = 2'd2;
  localparam logic [1:0] EVT_RESTART = 2'd3;

  localparam logic [1:0] CFG_ID_LENGTH  = 2'd0;
  localparam logic [1:0] CFG_PIN_LENGTH = 2'd1;
  localparam logic [1:0] CFG_LEVEL_LOW  = 2'd2;
  localparam logic [1:0] CFG_LEVEL_HIGH = 2'd3;

  localparam logic [3:0] RST_ID_LENGTH  = 4'd8;
  localparam logic [3:0] RST_PIN_LENGTH = 4'd5;
  localparam logic [3:0] RST_LEVEL_LOW  = 4'd1;
  localparam logic [3:0] RST_LEVEL_HIGH = 4'd3;

  localparam logic [3:0] DIGIT_EMPTY = 4'd15;
  localparam logic [3:0] DIGIT_MAX   = 4'd9;
  localparam logic [3:0] DIGIT_MIN   = 4'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CHANGE,
    ST_VAL,
    ST_OUT_RD,
    ST_FINISH
  } ede_state_t;

  typedef struct packed {
    logic cap_in;
    logic do_start;
    logic do_button;
    logic do_shift;
    logic do_change;
    logic val_clear;
    logic val_step;
    logic rd_val;
    logic load_out;
  } ede_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       need_val;
    logic       turn_edit;
    logic       turn_move;
    logic       val_done;
    logic       out_free;
  } ede_sts_t;

endpackage

`default_nettype wire

@@ rtl/ede_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ede_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire ede_pkg::ede_sts_t sts,
  output ede_pkg::ede_cmd_t     cmd
);
  import ede_pkg::*;

  ede_state_t state;
  ede_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.cap_in = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_next = ST_OUT_RD;
        unique case (sts.req)
          REQ_START: begin
            cmd.do_start = 1'b1;
          end
          REQ_BUTTON: begin
            cmd.do_button = 1'b1;
            if (sts.need_val) begin
              cmd.val_clear = 1'b1;
              state_next = ST_VAL;
            end
          end
          REQ_TURN: begin
            if (sts.turn_edit) begin
              state_next = ST_CHANGE;
            end else if (sts.turn_move) begin
              cmd.do_shift = 1'b1;
            end
          end
          default: begin
            state_next = ST_OUT_RD;
          end
        endcase
      end
      ST_CHANGE: begin
        cmd.do_change = 1'b1;
        state_next = ST_OUT_RD;
      end
      ST_VAL: begin
        cmd.rd_val = 1'b1;
        cmd.val_step = 1'b1;
        if (sts.val_done) begin
          state_next = ST_OUT_RD;
        end
      end
      ST_OUT_RD: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/ede_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ede_datapath #(
  parameter int MAX_DIGITS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [ede_pkg::IN_DATA_W-1:0]  s_tdata,
  input  wire logic [1:0]                     s_tuser,
  input  wire logic                           cfg_valid,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [3:0]                     cfg_data,
  input  wire ede_pkg::ede_cmd_t              cmd,
  output ede_pkg::ede_sts_t                   sts,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [ede_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic [1:0]                          m_tuser
);
  import ede_pkg::*;

  localparam int CW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int LW = $clog2(MAX_DIGITS + 1);
  localparam logic [4:0] MAX_LEN = 5'(MAX_DIGITS);

  logic [3:0] id_length;
  logic [3:0] pin_length;
  logic [3:0] level_low;
  logic [3:0] level_high;

  logic [1:0] req_type;
  logic [1:0] entry_mode;
  logic [1:0] button_kind;
  logic       turn_right;

  logic [1:0]            mode_reg;
  logic [CW-1:0]         cursor;
  logic                  edit_flag;
  logic [2:0]            last_button;
  logic [MAX_DIGITS-1:0] valid;
  logic [3:0]            mem [MAX_DIGITS];
  logic [3:0]            rd_data;
  logic                  rd_valid;

  logic [1:0]         event_reg;
  logic [VALUE_W-1:0] value_reg;
  logic [LW-1:0]      k;
  logic [VALUE_W-1:0] acc;
  logic               err;

  logic [4:0]         len5;
  logic [LW-1:0]      len;
  logic [3:0]         int_lo;
  logic [3:0]         int_hi;
  logic [3:0]         hi_clip;
  logic [3:0]         lo;
  logic [3:0]         hi;
  logic [3:0]         rd_digit;
  logic [LW:0]        cur_ext;
  logic [LW:0]        len_ext;
  logic               last_pin;
  logic               can_right;
  logic [3:0]         new_digit;
  logic [CW-1:0]      rd_addr;
  logic               wr_en;
  logic [CW-1:0]      wr_addr;
  logic [3:0]         wr_data;
  logic               val_done;
  logic               process;
  logic               skip;
  logic               bad;
  logic [VALUE_W-1:0] acc_mul;
  logic [VALUE_W-1:0] acc_next;
  logic               err_next;
  logic               release_ev;
  logic [CW+2:0]      pos_ext;

  function automatic logic [4:0] sat_len(input logic [3:0] v);
    logic [4:0] v5;
    v5 = {1'b0, v};
    if (v == 4'd0) begin
      sat_len = 5'd1;
    end else if (v5 > MAX_LEN) begin
      sat_len = MAX_LEN;
    end else begin
      sat_len = v5;
    end
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      id_length  <= RST_ID_LENGTH;
      pin_length <= RST_PIN_LENGTH;
      level_low  <= RST_LEVEL_LOW;
      level_high <= RST_LEVEL_HIGH;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ID_LENGTH:  id_length  <= cfg_data;
        CFG_PIN_LENGTH: pin_length <= cfg_data;
        CFG_LEVEL_LOW:  level_low  <= cfg_data;
        CFG_LEVEL_HIGH: level_high <= cfg_data;
        default:        id_length  <= id_length;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      req_type    <= s_tuser;
      entry_mode  <= s_tdata[1:0];
      button_kind <= s_tdata[3:2];
      turn_right  <= s_tdata[4];
    end
  end

  always_comb begin
    unique case (mode_reg)
      MODE_INTENSITY: len5 = 5'd1;
      MODE_IDENTITY:  len5 = sat_len(id_length);
      MODE_PIN:       len5 = sat_len(pin_length);
      default:        len5 = 5'd0;
    endcase
    len = len5[LW-1:0];

    int_lo  = (level_low > DIGIT_MAX) ? DIGIT_MAX : level_low;
    hi_clip = (level_high > DIGIT_MAX) ? DIGIT_MAX : level_high;
    int_hi  = (hi_clip < int_lo) ? int_lo : hi_clip;
    lo = (mode_reg == MODE_INTENSITY) ? int_lo : DIGIT_MIN;
    hi = (mode_reg == MODE_INTENSITY) ? int_hi : DIGIT_MAX;

    rd_digit  = rd_valid ? rd_data : DIGIT_EMPTY;
    cur_ext   = (LW+1)'(cursor);
    len_ext   = (LW+1)'(len);
    last_pin  = (mode_reg == MODE_PIN) && (cur_ext + 1'b1 == len_ext);
    can_right = (cur_ext + 1'b1 < len_ext);

    // digit step with wrap, optional last pin digit may go empty
    if (turn_right) begin
      if (rd_digit == DIGIT_EMPTY) begin
        new_digit = lo;
      end else if (last_pin && rd_digit == DIGIT_MAX) begin
        new_digit = DIGIT_EMPTY;
      end else if (rd_digit >= hi || rd_digit < lo) begin
        new_digit = lo;
      end else begin
        new_digit = rd_digit + 4'd1;
      end
    end else begin
      if (rd_digit == DIGIT_EMPTY) begin
        new_digit = hi;
      end else if (last_pin && rd_digit == DIGIT_MIN) begin
        new_digit = DIGIT_EMPTY;
      end else if (rd_digit <= lo || rd_digit > hi) begin
        new_digit = hi;
      end else begin
        new_digit = rd_digit - 4'd1;
      end
    end

    if (cmd.rd_val) begin
      rd_addr = (k < len) ? k[CW-1:0] : '0;
    end else begin
      rd_addr = cursor;
    end

    wr_en   = cmd.do_change || (cmd.do_start && entry_mode == MODE_INTENSITY);
    wr_addr = cmd.do_change ? cursor : '0;
    wr_data = cmd.do_change ? new_digit : int_hi;

    // validation walk, read data is registered and belongs to the previous index
    val_done = (k == len);
    process  = (k != '0);
    skip     = (mode_reg == MODE_PIN) && val_done && (rd_digit == DIGIT_EMPTY);
    bad      = (rd_digit < lo) || (rd_digit > hi);
    acc_mul  = {acc[VALUE_W-4:0], 3'b000} + {acc[VALUE_W-2:0], 1'b0} + VALUE_W'(rd_digit);
    acc_next = (process && !skip && !bad) ? acc_mul : acc;
    err_next = err || (process && !skip && bad);

    release_ev = ({1'b0, button_kind} == BTN_RELEASE);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data  <= mem[rd_addr];
    rd_valid <= valid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg    <= MODE_IDENTITY;
      cursor      <= '0;
      edit_flag   <= 1'b0;
      last_button <= BTN_NONE;
      valid       <= '0;
    end else begin
      if (cmd.do_start) begin
        mode_reg  <= entry_mode;
        cursor    <= '0;
        edit_flag <= (entry_mode == MODE_INTENSITY);
        valid     <= (entry_mode == MODE_INTENSITY) ? MAX_DIGITS'(1) : '0;
      end
      if (cmd.do_button) begin
        if (release_ev && mode_reg != MODE_OPEN && last_button == BTN_PRESS) begin
          edit_flag <= !edit_flag;
        end
        last_button <= {1'b0, button_kind};
      end
      if (cmd.do_shift) begin
        if (turn_right) begin
          if (can_right) begin
            cursor <= cursor + 1'b1;
          end
        end else if (cursor != '0) begin
          cursor <= cursor - 1'b1;
        end
      end
      if (cmd.do_change) begin
        valid[cursor] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.val_clear) begin
      k   <= '0;
      acc <= '0;
      err <= 1'b0;
    end else if (cmd.val_step) begin
      k   <= k + 1'b1;
      acc <= acc_next;
      err <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      event_reg <= EVT_NONE;
      value_reg <= '0;
    end else if (cmd.do_button && release_ev) begin
      if (mode_reg == MODE_OPEN || last_button == BTN_TYPEMATIC) begin
        event_reg <= EVT_RESTART;
      end
    end else if (cmd.val_step && val_done) begin
      if (err_next) begin
        event_reg <= EVT_ERROR;
        value_reg <= '0;
      end else begin
        event_reg <= EVT_NUMBER;
        value_reg <= acc_next;
      end
    end
  end

  assign pos_ext = (CW+3)'(cursor);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tuser <= event_reg;
      m_tdata <= {5'b00000, rd_digit, edit_flag, pos_ext[2:0], value_reg};
    end
  end

  always_comb begin
    sts.req       = req_type;
    sts.need_val  = release_ev && (mode_reg != MODE_OPEN) && (last_button == BTN_LONG);
    sts.turn_edit = (mode_reg != MODE_OPEN) && edit_flag;
    sts.turn_move = (mode_reg != MODE_OPEN) && !edit_flag;
    sts.val_done  = val_done;
    sts.out_free  = !m_tvalid || m_tready;
  end

endmodule

`default_nettype wire

@@ rtl/encoder_digit_entry.sv @@
// channel   dir  signals                              payload
// s         in   s_tvalid s_tready s_tdata s_tuser   one request
// m         out  m_tvalid m_tready m_tdata m_tuser   one result per request
// cfg       in   cfg_valid cfg_ready cfg_index cfg_data  register write
//
// one request at a time: dispatch, output read and finish steps lead to the result, an
// edit turn adds a change step, a release after long press adds a digit walk (one
// store read per cycle); ready again the cycle after the result loads.
// the output register lets a new request enter while a result waits.
// reset is synchronous; digits empty through per-entry valid bits, no sweep.
`timescale 1ns / 1ps
`default_nettype none

module encoder_digit_entry #(
  parameter int MAX_DIGITS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // entry_mode[1:0], button_kind[3:2], turn_right[4], zero pad
  input  wire logic [ede_pkg::IN_DATA_W-1:0]  s_tdata,
  // req_type[1:0]
  input  wire logic [1:0]                     s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // entered_value[26:0], cursor_pos[29:27], editing[30],
  // cursor_digit[34:31], zero pad
  output logic [ede_pkg::OUT_DATA_W-1:0]      m_tdata,
  // entry_event[1:0]
  output logic [1:0]                          m_tuser,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [3:0]                     cfg_data
);
  import ede_pkg::*;

  ede_cmd_t cmd;
  ede_sts_t sts;

  assign cfg_ready = 1'b1;

  ede_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ede_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire

@@ rtl/ede_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ede_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic [ede_pkg::IN_DATA_W-1:0]  s_tdata,
  input wire logic [1:0]                     s_tuser,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [ede_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic [1:0]                     m_tuser,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready,
  input wire logic [1:0]                     cfg_index,
  input wire logic [3:0]                     cfg_data
);
  import ede_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while one is in progress");

  a_digit_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[34:31] <= DIGIT_MAX) || (m_tdata[34:31] == DIGIT_EMPTY))
    else $error("cursor digit is not a digit or empty");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != EVT_NUMBER) |-> (m_tdata[26:0] == '0))
    else $error("value set without a number event");

endmodule

bind encoder_digit_entry ede_checker u_ede_checker (.*);

`default_nettype wire
